[hw/rtl/mfde_pkg.sv]
package mfde_pkg;

  // command opcodes
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PIXEL = 3'd1;
  localparam logic [2:0] OP_VLINE = 3'd2;
  localparam logic [2:0] OP_HLINE = 3'd3;
  localparam logic [2:0] OP_LINE  = 3'd4;
  localparam logic [2:0] OP_RECT  = 3'd5;
  localparam logic [2:0] OP_FILL  = 3'd6;
  localparam logic [2:0] OP_READ  = 3'd7;

  localparam int MAX_ROWS  = 64;
  localparam int OUT_DEPTH = 2;
  localparam int JOB_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_COLS,
    KIND_LINE,
    KIND_READ
  } kind_e;

  // one classified command as handed from front to back
  typedef struct packed {
    kind_e                kind;
    logic [7:0]           col;
    logic [7:0]           row;
    logic [8:0]           count;
    logic [MAX_ROWS-1:0]  edge_mask;
    logic [MAX_ROWS-1:0]  body_mask;
    logic                 major_x;
    logic                 major_neg;
    logic                 minor_neg;
    logic [7:0]           major_len;
    logic [7:0]           minor_len;
    logic [2:0]           page;
  } job_t;

  function automatic logic [MAX_ROWS-1:0] low_bits(logic [6:0] n);
    logic [MAX_ROWS-1:0] m;
    if (n >= 7'd64) begin
      m = '1;
    end else begin
      m = (MAX_ROWS'(1) << n[5:0]) - MAX_ROWS'(1);
    end
    return m;
  endfunction

  // rows [start, start+len) clipped to rows
  function automatic logic [MAX_ROWS-1:0] row_mask(logic [8:0] start, logic [8:0] len,
                                                   logic [6:0] rows);
    logic [9:0]          stop;
    logic [MAX_ROWS-1:0] m;
    stop = {1'b0, start} + {1'b0, len};
    if (stop > {3'b0, rows}) begin
      stop = {3'b0, rows};
    end
    if (len == 9'd0 || start >= {2'b0, rows}) begin
      m = '0;
    end else begin
      m = low_bits(stop[6:0]) & ~low_bits(start[6:0]);
    end
    return m;
  endfunction

endpackage

[hw/rtl/mfde_fifo.sv]
module mfde_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

[hw/rtl/mfde_front.sv]
module mfde_front #(
  parameter int PAGES = 8
) (
  input  logic          [2:0] opcode_i,
  input  logic          [7:0] x_i,
  input  logic          [7:0] y_i,
  input  logic          [7:0] x_end_i,
  input  logic          [7:0] y_end_i,
  input  logic          [7:0] span_i,
  input  logic          [7:0] rect_width_i,
  input  logic          [7:0] rect_height_i,
  input  logic          [2:0] page_i,
  output mfde_pkg::job_t      job_o
);
  import mfde_pkg::*;

  localparam logic [6:0] ROWS = 7'(PAGES * 8);

  logic [8:0] dx, dy, ax, ay, bottom;
  logic       empty_box, major_x;

  always_comb begin
    dx        = {1'b0, x_end_i} - {1'b0, x_i};
    dy        = {1'b0, y_end_i} - {1'b0, y_i};
    ax        = dx[8] ? -dx : dx;
    ay        = dy[8] ? -dy : dy;
    major_x   = ax > ay;
    empty_box = (rect_width_i == 8'd0) || (rect_height_i == 8'd0);
    bottom    = {1'b0, y_i} + {1'b0, rect_height_i} - 9'd1;

    job_o           = '0;
    job_o.col       = x_i;
    job_o.row       = y_i;
    job_o.page      = page_i;
    job_o.major_x   = major_x;
    job_o.major_neg = major_x ? dx[8] : dy[8];
    job_o.minor_neg = major_x ? dy[8] : dx[8];
    job_o.major_len = major_x ? ax[7:0] : ay[7:0];
    job_o.minor_len = major_x ? ay[7:0] : ax[7:0];

    case (opcode_i)
      OP_CLEAR: begin
        job_o.kind = KIND_CLEAR;
      end
      OP_PIXEL: begin
        job_o.kind      = KIND_COLS;
        job_o.count     = 9'd1;
        job_o.edge_mask = row_mask({1'b0, y_i}, 9'd1, ROWS);
        job_o.body_mask = job_o.edge_mask;
      end
      OP_VLINE: begin
        job_o.kind      = KIND_COLS;
        job_o.count     = 9'd1;
        job_o.edge_mask = row_mask({1'b0, y_i}, {1'b0, span_i}, ROWS);
        job_o.body_mask = job_o.edge_mask;
      end
      OP_HLINE: begin
        job_o.kind      = KIND_COLS;
        job_o.count     = {1'b0, span_i};
        job_o.edge_mask = row_mask({1'b0, y_i}, 9'd1, ROWS);
        job_o.body_mask = job_o.edge_mask;
      end
      OP_LINE: begin
        job_o.kind = KIND_LINE;
      end
      OP_RECT: begin
        job_o.kind      = KIND_COLS;
        job_o.count     = empty_box ? 9'd0 : {1'b0, rect_width_i};
        job_o.edge_mask = row_mask({1'b0, y_i}, {1'b0, rect_height_i}, ROWS);
        job_o.body_mask = row_mask({1'b0, y_i}, 9'd1, ROWS)
                        | row_mask(bottom, 9'd1, ROWS);
      end
      OP_FILL: begin
        job_o.kind      = KIND_COLS;
        job_o.count     = empty_box ? 9'd0 : {1'b0, rect_width_i};
        job_o.edge_mask = row_mask({1'b0, y_i}, {1'b0, rect_height_i}, ROWS);
        job_o.body_mask = job_o.edge_mask;
      end
      default: begin
        job_o.kind = KIND_READ;
      end
    endcase
  end

endmodule

[hw/rtl/mfde_back.sv]
module mfde_back #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mfde_pkg::job_t       job_i,
  input  logic                 job_empty_i,
  output logic                 job_pop_o,
  input  logic [1:0]           out_count_i,
  input  logic                 out_full_i,
  output logic                 out_push_o,
  output logic [7:0]           out_byte_o
);
  import mfde_pkg::*;

  localparam int ROWS = PAGES * 8;
  localparam int AW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ONE  = 2'd1;
  localparam logic [1:0] ST_COLS = 2'd2;
  localparam logic [1:0] ST_LINE = 2'd3;

  localparam logic [1:0] OPK_WRITE = 2'd0;
  localparam logic [1:0] OPK_READ  = 2'd1;
  localparam logic [1:0] OPK_CLEAR = 2'd2;

  // sequencer
  logic [1:0] state_q, state_d;
  job_t       cur_q, cur_d;
  logic [8:0] c_q, c_d, left_q, left_d, last_q, last_d;
  logic [9:0] maj_q, maj_d, min_q, min_d;
  logic [7:0] rem_q, rem_d;

  // issued op
  logic            iss_valid;
  logic [1:0]      iss_kind;
  logic [AW-1:0]   iss_addr;
  logic [ROWS-1:0] iss_mask;
  logic            iss_zero;

  logic [9:0] pcol, prow;
  logic       on_screen, credit, c_out;
  logic [8:0] sum;

  // column update stage
  logic            s1_valid_q;
  logic [1:0]      s1_kind_q;
  logic [AW-1:0]   s1_addr_q;
  logic [ROWS-1:0] s1_mask_q;
  logic [2:0]      s1_page_q;
  logic            s1_zero_q;
  logic [ROWS-1:0] rd_data_q;
  logic            rd_vld_q;
  logic            lw_valid_q;
  logic [AW-1:0]   lw_addr_q;
  logic [ROWS-1:0] lw_data_q;
  logic            prev_clr_q;
  logic [ROWS-1:0] mem_q [COLUMNS];
  logic [COLUMNS-1:0] valid_q;

  logic [ROWS-1:0] base, merged;
  logic [63:0]     base_ext;

  assign pcol      = cur_q.major_x ? maj_q : min_q;
  assign prow      = cur_q.major_x ? min_q : maj_q;
  assign on_screen = !pcol[9] && (pcol[8:0] < 9'(COLUMNS)) && !prow[9] && (prow[8:0] < 9'(ROWS));
  assign credit    = ({1'b0, out_count_i} + ((s1_valid_q && s1_kind_q == OPK_READ) ? 3'd1 : 3'd0))
                     < 3'(OUT_DEPTH);
  assign c_out     = (left_q == 9'd0) || (c_q >= 9'(COLUMNS));
  assign sum       = {1'b0, rem_q} + {1'b0, cur_q.minor_len};

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    c_d       = c_q;
    left_d    = left_q;
    last_d    = last_q;
    maj_d     = maj_q;
    min_d     = min_q;
    rem_d     = rem_q;
    job_pop_o = 1'b0;
    iss_valid = 1'b0;
    iss_kind  = OPK_WRITE;
    iss_addr  = '0;
    iss_mask  = '0;
    iss_zero  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          cur_d     = job_i;
          c_d       = {1'b0, job_i.col};
          last_d    = {1'b0, job_i.col} + job_i.count - 9'd1;
          left_d    = (job_i.kind == KIND_LINE) ? {1'b0, job_i.major_len} : job_i.count;
          maj_d     = job_i.major_x ? {2'b0, job_i.col} : {2'b0, job_i.row};
          min_d     = job_i.major_x ? {2'b0, job_i.row} : {2'b0, job_i.col};
          rem_d     = '0;
          case (job_i.kind)
            KIND_COLS: state_d = ST_COLS;
            KIND_LINE: state_d = ST_LINE;
            default:   state_d = ST_ONE;
          endcase
        end
      end
      ST_ONE: begin
        if (cur_q.kind == KIND_CLEAR) begin
          iss_valid = 1'b1;
          iss_kind  = OPK_CLEAR;
          state_d   = ST_IDLE;
        end else if (credit) begin
          iss_valid = 1'b1;
          iss_kind  = OPK_READ;
          iss_zero  = ({1'b0, cur_q.col} >= 9'(COLUMNS)) || ({1'b0, cur_q.page} >= 4'(PAGES));
          iss_addr  = iss_zero ? '0 : cur_q.col[AW-1:0];
          state_d   = ST_IDLE;
        end
      end
      ST_COLS: begin
        if (c_out) begin
          state_d = ST_IDLE;
        end else begin
          iss_valid = 1'b1;
          iss_addr  = c_q[AW-1:0];
          iss_mask  = (c_q == {1'b0, cur_q.col} || c_q == last_q) ?
                      cur_q.edge_mask[ROWS-1:0] : cur_q.body_mask[ROWS-1:0];
          c_d       = c_q + 9'd1;
          left_d    = left_q - 9'd1;
        end
      end
      default: begin
        if (on_screen) begin
          iss_valid = 1'b1;
          iss_addr  = pcol[AW-1:0];
          iss_mask  = ROWS'(1) << prow[5:0];
        end
        if (left_q == 9'd0) begin
          state_d = ST_IDLE;
        end else begin
          left_d = left_q - 9'd1;
          maj_d  = cur_q.major_neg ? maj_q - 10'd1 : maj_q + 10'd1;
          if (sum >= {1'b0, cur_q.major_len}) begin
            rem_d = 8'(sum - {1'b0, cur_q.major_len});
            min_d = cur_q.minor_neg ? min_q - 10'd1 : min_q + 10'd1;
          end else begin
            rem_d = sum[7:0];
          end
        end
      end
    endcase
  end

  // old column: a clear from the previous cycle wins, then a write from the previous cycle to the same column
  always_comb begin
    if (prev_clr_q) begin
      base = '0;
    end else if (lw_valid_q && lw_addr_q == s1_addr_q) begin
      base = lw_data_q;
    end else if (rd_vld_q) begin
      base = rd_data_q;
    end else begin
      base = '0;
    end
    merged   = base | s1_mask_q;
    base_ext = 64'(base);
  end

  assign out_push_o = s1_valid_q && s1_kind_q == OPK_READ;
  assign out_byte_o = s1_zero_q ? 8'd0 : base_ext[{s1_page_q, 3'b000} +: 8];

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[iss_addr];
    s1_kind_q <= iss_kind;
    s1_addr_q <= iss_addr;
    s1_mask_q <= iss_mask;
    s1_page_q <= cur_q.page;
    s1_zero_q <= iss_zero;
    lw_addr_q <= s1_addr_q;
    lw_data_q <= merged;
    cur_q     <= cur_d;
    c_q       <= c_d;
    left_q    <= left_d;
    last_q    <= last_d;
    maj_q     <= maj_d;
    min_q     <= min_d;
    rem_q     <= rem_d;
    if (s1_valid_q && s1_kind_q == OPK_WRITE) begin
      mem_q[s1_addr_q] <= merged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      s1_valid_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      lw_valid_q <= 1'b0;
      prev_clr_q <= 1'b0;
      valid_q    <= '0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= iss_valid;
      rd_vld_q   <= valid_q[iss_addr];
      lw_valid_q <= s1_valid_q && s1_kind_q == OPK_WRITE;
      prev_clr_q <= s1_valid_q && s1_kind_q == OPK_CLEAR;
      if (s1_valid_q && s1_kind_q == OPK_CLEAR) begin
        valid_q <= '0;
      end else if (s1_valid_q && s1_kind_q == OPK_WRITE) begin
        valid_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  a_no_out_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i) else $error("result queue overflow");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> state_q == ST_IDLE) else $error("job taken while busy");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iss_valid && iss_kind == OPK_WRITE) |-> ({1'b0, iss_addr} < (AW + 1)'(COLUMNS)))
    else $error("column write out of range");

  a_clear_then_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_kind_q == OPK_CLEAR) |=> (prev_clr_q && !lw_valid_q))
    else $error("clear bypass lost");

endmodule

[hw/rtl/mono_framebuffer_draw_engine.sv]
// Monochrome 2D drawing engine over a COLUMNS x (PAGES*8) framebuffer held as one word per
// column (bit 0 = top row), all clear after reset. Commands go in through a queue-style
// port (push/full) and only READ returns a transfer, on the result side (empty/pop, oldest
// first). Drawing only ORs pixels in and anything off screen is dropped. A front decoder
// classifies each command into a job (column run with edge/body row masks, line, clear, read)
// and drops it into a two-entry job queue; the back sequencer turns each job into column
// read-modify-write operations on the framebuffer memory at one column per cycle. At the back,
// clear and read are single operations; pixel and vline touch one column; hline, rectangle
// and filled rectangle run over their span or width (columns past the right edge end the run
// early); a general line runs over max(|dx|,|dy|)+1 pixels, one pixel per step.
// Clear takes effect at once through per-column valid bits, so there is no clearing pass.
module mono_framebuffer_draw_engine #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] opcode_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic [7:0] x_end_i,
  input  logic [7:0] y_end_i,
  input  logic [7:0] span_i,
  input  logic [7:0] rect_width_i,
  input  logic [7:0] rect_height_i,
  input  logic [2:0] page_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] page_byte_o
);
  import mfde_pkg::*;

  job_t       dec_job, job_head;
  logic       job_empty, job_pop;
  logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
  logic [1:0] out_count;
  logic       out_full, out_push;
  logic [7:0] out_byte;

  // front: classify the command as it is transferred in
  mfde_front #(.PAGES(PAGES)) u_front (
    .opcode_i      (opcode_i),
    .x_i           (x_i),
    .y_i           (y_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .span_i        (span_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .page_i        (page_i),
    .job_o         (dec_job)
  );

  // decouples decode from drawing
  mfde_fifo #(.WIDTH($bits(job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (dec_job),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_head),
    .empty_o (job_empty),
    .count_o (job_count)
  );

  // back: sequencer plus framebuffer update pipeline
  mfde_back #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_empty_i (job_empty || (job_count == '0)),
    .job_pop_o   (job_pop),
    .out_count_i (out_count),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_byte_o  (out_byte)
  );

  // read results wait here; the back only issues a read when a slot is free
  mfde_fifo #(.WIDTH(8), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_byte),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (page_byte_o),
    .empty_o (empty),
    .count_o (out_count)
  );

endmodule

[verif/mono_framebuffer_draw_engine_test.sv]
module mono_framebuffer_draw_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mfde_pkg::*;

  localparam int COLS = 128;
  localparam int ROWS = 64;
  localparam int NUM_RANDOM = 1750;

  // one command as seen on the input ports
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] xe;
    logic [7:0] ye;
    logic [7:0] span;
    logic [7:0] w;
    logic [7:0] h;
    logic [2:0] pg;
  } cmd_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [2:0] opcode_i = '0;
  logic [7:0] x_i = '0;
  logic [7:0] y_i = '0;
  logic [7:0] x_end_i = '0;
  logic [7:0] y_end_i = '0;
  logic [7:0] span_i = '0;
  logic [7:0] rect_width_i = '0;
  logic [7:0] rect_height_i = '0;
  logic [2:0] page_i = '0;
  logic [7:0] page_byte_o;

  mono_framebuffer_draw_engine uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .opcode_i(opcode_i), .x_i(x_i), .y_i(y_i), .x_end_i(x_end_i), .y_end_i(y_end_i),
    .span_i(span_i), .rect_width_i(rect_width_i), .rect_height_i(rect_height_i),
    .page_i(page_i), .empty(empty), .pop(pop), .page_byte_o(page_byte_o)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow framebuffer and expected page bytes
  // --------------------------------------------------------------------------
  logic [ROWS-1:0] shadow_fb [COLS];
  logic [7:0]      page_bytes_due [$];
  cmd_t            cmd_queue [$];
  int              mismatches = 0;
  bit              hold_off = 1'b0;  // receiver stall forced from the stimulus process

  function automatic logic [ROWS-1:0] span_rows(int start, int len);
    logic [ROWS-1:0] m;
    m = '0;
    for (int r = start; r < start + len; r++)
      if (r >= 0 && r < ROWS) m[r] = 1'b1;
    return m;
  endfunction

  function automatic void set_px(int c, int r);
    if (c >= 0 && c < COLS && r >= 0 && r < ROWS) shadow_fb[c][r] = 1'b1;
  endfunction

  function automatic void or_cols(int start, int len, logic [ROWS-1:0] m);
    for (int c = start; c < start + len && c < COLS; c++)
      if (c >= 0) shadow_fb[c] |= m;
  endfunction

  // Stepped line: minor offset is a truncated quotient, no 8-bit wrap.
  function automatic void trace_line(int x0, int y0, int x1, int y1);
    int dx, dy, ax, ay, s, off;
    dx = x1 - x0;
    dy = y1 - y0;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax == 0 && ay == 0) begin
      set_px(x0, y0);
    end else if (ax > ay) begin
      s = dx < 0 ? -1 : 1;
      for (int i = 0; i <= ax; i++) begin
        off = (i * s * dy) / dx;
        set_px(x0 + i * s, y0 + off);
      end
    end else begin
      s = dy < 0 ? -1 : 1;
      for (int i = 0; i <= ay; i++) begin
        off = (i * s * dx) / dy;
        set_px(x0 + off, y0 + i * s);
      end
    end
  endfunction

  // Applies one accepted command; queues the page byte of a read.
  function automatic void apply_cmd(cmd_t c);
    int x, y, w, h;
    x = c.x;
    y = c.y;
    w = c.w;
    h = c.h;
    case (c.op)
      OP_CLEAR: for (int i = 0; i < COLS; i++) shadow_fb[i] = '0;
      OP_PIXEL: set_px(x, y);
      OP_VLINE: or_cols(x, 1, span_rows(y, c.span));
      OP_HLINE: or_cols(x, c.span, span_rows(y, 1));
      OP_LINE:  trace_line(x, y, c.xe, c.ye);
      OP_RECT: begin
        if (w != 0 && h != 0) begin
          or_cols(x, 1, span_rows(y, h));
          or_cols(x + w - 1, 1, span_rows(y, h));
          or_cols(x, w, span_rows(y, 1) | span_rows(y + h - 1, 1));
        end
      end
      OP_FILL: if (w != 0 && h != 0) or_cols(x, w, span_rows(y, h));
      default: begin
        if (x < COLS) page_bytes_due.push_back(shadow_fb[x][c.pg*8 +: 8]);
        else page_bytes_due.push_back(8'h00);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued commands with random gaps
  // --------------------------------------------------------------------------
  int send_gap = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  always @(posedge clk_i) begin
    cmd_t c;
    if (rst_ni) begin
      // a transfer happened at this edge
      if (push && !full) begin
        c = {opcode_i, x_i, y_i, x_end_i, y_end_i, span_i, rect_width_i,
             rect_height_i, page_i};
        apply_cmd(c);
        void'(cmd_queue.pop_front());
        send_gap = pick_gap();
      end
      if (send_gap > 0 && !(push && full)) begin
        push <= 1'b0;
        send_gap--;
      end else if (cmd_queue.size() > 0) begin
        c = cmd_queue[0];
        push          <= 1'b1;
        opcode_i      <= c.op;
        x_i           <= c.x;
        y_i           <= c.y;
        x_end_i       <= c.xe;
        y_end_i       <= c.ye;
        span_i        <= c.span;
        rect_width_i  <= c.w;
        rect_height_i <= c.h;
        page_i        <= c.pg;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: pops with random stalls, checks page bytes in order
  // --------------------------------------------------------------------------
  int pop_gap = 0;

  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (page_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected page byte %02h", page_byte_o));
        end else begin
          want = page_bytes_due.pop_front();
          if (page_byte_o !== want)
            report_mismatch($sformatf("page_byte got %02h want %02h", page_byte_o, want));
        end
        pop_gap = pick_gap();
      end
      if (hold_off) begin
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic cmd_t make_cmd(logic [2:0] op, int x, int y, int xe, int ye,
                                    int span, int w, int h, int pg);
    cmd_t c;
    c.op = op; c.x = 8'(x); c.y = 8'(y); c.xe = 8'(xe); c.ye = 8'(ye);
    c.span = 8'(span); c.w = 8'(w); c.h = 8'(h); c.pg = 3'(pg);
    return c;
  endfunction

  // Coordinates mostly on screen, sometimes near or past the edges.
  function automatic int coord(int lim);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, lim - 1);
    if (r < 9) return $urandom_range(lim - 4, lim + 4);
    return $urandom_range(0, 255);
  endfunction

  function automatic int extent();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r < 8) return $urandom_range(1, 24);
    return $urandom_range(0, 255);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.op = $urandom_range(0, 99) < 2 ? OP_CLEAR : 3'($urandom_range(1, 7));
    c.x = 8'(coord(COLS));
    c.y = 8'(coord(ROWS));
    c.xe = 8'(coord(COLS));
    c.ye = 8'(coord(ROWS));
    c.span = 8'(extent());
    c.w = 8'(extent());
    c.h = 8'(extent());
    c.pg = 3'($urandom_range(0, 7));
    if (c.op == OP_READ && $urandom_range(0, 9) != 0) c.x = 8'($urandom_range(0, COLS - 1));
    return c;
  endfunction

  task automatic drain();
    while (cmd_queue.size() > 0 || page_bytes_due.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: each command kind, edges, zero sizes, off-screen cases
    cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_PIXEL, 127, 63, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_PIXEL, 255, 255, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_VLINE, 5, 60, 0, 0, 255, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_VLINE, 6, 3, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_HLINE, 120, 9, 0, 0, 255, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_HLINE, 10, 10, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_LINE, 20, 20, 20, 20, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_LINE, 0, 63, 255, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_LINE, 127, 0, 100, 255, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_RECT, 30, 30, 0, 0, 0, 255, 255, 0));
    cmd_queue.push_back(make_cmd(OP_RECT, 40, 40, 0, 0, 0, 0, 5, 0));
    cmd_queue.push_back(make_cmd(OP_FILL, 50, 8, 0, 0, 0, 3, 0, 0));
    cmd_queue.push_back(make_cmd(OP_FILL, 60, 16, 0, 0, 0, 4, 8, 0));
    cmd_queue.push_back(make_cmd(OP_READ, 127, 0, 0, 0, 0, 0, 0, 7));
    cmd_queue.push_back(make_cmd(OP_READ, 5, 0, 0, 0, 0, 0, 0, 7));
    cmd_queue.push_back(make_cmd(OP_READ, 61, 0, 0, 0, 0, 0, 0, 2));
    cmd_queue.push_back(make_cmd(OP_READ, 128, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_READ, 255, 0, 0, 0, 0, 0, 0, 3));
    cmd_queue.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // long receiver stall while reads keep coming, so the block backs up
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++)
      cmd_queue.push_back(make_cmd(OP_READ, i, 0, 0, 0, 0, 0, 0, i % 8));
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
    drain();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      cmd_queue.push_back(random_cmd());
      if (cmd_queue.size() > 16) @(posedge clk_i iff cmd_queue.size() <= 16);
    end
    drain();
    repeat (300) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    for (int i = 0; i < COLS; i++) shadow_fb[i] = '0;
  end

  // run limit: far beyond the slowest legal run of commands plus stalls
  initial begin
    #(20ns * 2000000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
